@@ src/hpo_pkg.sv @@
// Shared types and constants for the haversine path odometer.
// No dependencies.
`default_nettype none
package hpo_pkg;

  localparam logic [63:0] PiQ60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] RadScale = PiQ60 / 64'd5898240;
  localparam logic [31:0] FullTurn = 32'd3019898880;
  localparam logic [31:0] QuarterTurn = 32'd754974720;
  localparam logic [63:0] OneQ60 = 64'h1000000000000000;
  localparam logic [63:0] DiamScale = 64'd3261952000;
  localparam logic [6:0] ShiftRad = 7'd8;
  localparam logic [6:0] ShiftQ60 = 7'd60;
  localparam int unsigned CordicSteps = 61;
  localparam int unsigned TaylorTerms = 13;

  typedef logic [63:0][63:0] atan_tab_t;
  typedef logic [15:0][63:0] recip_tab_t;
  typedef logic [15:0][6:0] shift_tab_t;

  typedef struct packed {
    logic first;
    logic [3:0][31:0] ang;
  } hpo_job_t;

  typedef struct packed {
    logic go;
    logic rnd;
    logic [6:0] shift;
    logic [63:0] a;
    logic [63:0] b;
  } hpo_mul_req_t;

  function automatic atan_tab_t atan_table();
    atan_tab_t t;
    logic [63:0] sum;
    logic [63:0] term;
    t = '0;
    t[0] = (PiQ60 + 64'd2) >> 2;
    for (int i = 1; i < 61; i++) begin
      sum = '0;
      for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
        term = (64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1);
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      t[i] = sum;
    end
    return t;
  endfunction

  // Series divisor for term n: 2n(2n+1) for sine, (2n-1)2n for cosine.
  // Numerators stay below 2^62, so floor(N*m >> (62+clog2 d)) with
  // m = ceil(2^(62+clog2 d) / d) is the exact quotient and m fits 64 bits.
  function automatic recip_tab_t recip_table(input bit cos_kind);
    recip_tab_t t;
    logic [127:0] num;
    int d;
    t = '0;
    for (int n = 1; n <= int'(TaylorTerms); n++) begin
      d = cos_kind ? (2 * n - 1) * (2 * n) : (2 * n) * (2 * n + 1);
      num = 128'd1 << (62 + $clog2(d));
      t[n] = 64'((num + 128'(d - 1)) / 128'(d));
    end
    return t;
  endfunction

  function automatic shift_tab_t shift_table(input bit cos_kind);
    shift_tab_t t;
    int d;
    t = '0;
    for (int n = 1; n <= int'(TaylorTerms); n++) begin
      d = cos_kind ? (2 * n - 1) * (2 * n) : (2 * n) * (2 * n + 1);
      t[n] = 7'(62 + $clog2(d));
    end
    return t;
  endfunction

  localparam atan_tab_t AtanTab = atan_table();
  localparam recip_tab_t SinRecip = recip_table(1'b0);
  localparam recip_tab_t CosRecip = recip_table(1'b1);
  localparam shift_tab_t SinShift = shift_table(1'b0);
  localparam shift_tab_t CosShift = shift_table(1'b1);

endpackage
`default_nettype wire

@@ src/hpo_front.sv @@
// Front end: holds the previous fix and turns each fix into one job of four angles.
// Depends on hpo_pkg.
`default_nettype none
module hpo_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [29:0]      latitude,
  input  wire logic [30:0]      longitude,
  output hpo_pkg::hpo_job_t     job
);

  logic [29:0] prev_lat;
  logic [30:0] prev_lon;
  logic        have_prev;

  logic signed [31:0] la1, la2, lo1, lo2;

  always_comb begin
    la1 = 32'(signed'(prev_lat));
    la2 = 32'(signed'(latitude));
    lo1 = 32'(signed'(prev_lon));
    lo2 = 32'(signed'(longitude));
    job.first  = !have_prev;
    job.ang[0] = la2 - la1;
    job.ang[1] = lo2 - lo1;
    job.ang[2] = la1 <<< 1;
    job.ang[3] = la2 <<< 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_lat  <= '0;
      prev_lon  <= '0;
      have_prev <= 1'b0;
    end else if (accept) begin
      prev_lat  <= latitude;
      prev_lon  <= longitude;
      have_prev <= 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ src/hpo_queue.sv @@
// Two-entry job queue between front and back end.
// Depends on hpo_pkg.
`default_nettype none
module hpo_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  hpo_pkg::hpo_job_t      push_data,
  output logic                   full,
  input  wire logic              pop,
  output hpo_pkg::hpo_job_t      pop_data,
  output logic                   empty
);

  hpo_pkg::hpo_job_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign empty    = count == 2'd0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

@@ src/hpo_mul.sv @@
// 64x64 multiplier over four 32x32 partial products, right shift with optional rounding.
// Depends on hpo_pkg.
`default_nettype none
module hpo_mul (
  input  wire logic             clk,
  input  wire logic             rst,
  input  hpo_pkg::hpo_mul_req_t req,
  output logic                  done,
  output logic [63:0]           res
);

  logic [63:0]  a, b;
  logic         rnd;
  logic [6:0]   shift;
  logic [127:0] acc;
  logic [2:0]   cnt;
  logic         busy;

  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [6:0]   sh;
  logic [127:0] rsum;

  always_comb begin
    pa   = cnt[0] ? a[63:32] : a[31:0];
    pb   = cnt[1] ? b[63:32] : b[31:0];
    pp   = 64'(pa) * 64'(pb);
    sh   = {1'b0, cnt[0] & cnt[1], cnt[0] ^ cnt[1], 4'b0} << 1;
    rsum = acc + (rnd ? (128'd1 << (shift - 7'd1)) : 128'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        a     <= req.a;
        b     <= req.b;
        rnd   <= req.rnd;
        shift <= req.shift;
        acc   <= '0;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (cnt == 3'd4) begin
          res  <= 64'(rsum >> shift);
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          acc <= acc + (128'(pp) << sh);
          cnt <= cnt + 3'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ src/hpo_back.sv @@
// Back end: sine/cosine series, haversine term, square roots, CORDIC arctangent,
// running total and output register. Depends on hpo_pkg and hpo_mul.
`default_nettype none
module hpo_back #(
  parameter int TOTAL_WIDTH = 48
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          job_avail,
  input  hpo_pkg::hpo_job_t  job,
  output logic               job_pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [47:0]        total_path,
  output logic [32:0]        segment_length
);

  typedef enum logic [4:0] {
    IDLE, ANG, MX, MX2, MTS, DTS, MTC, DTC, QUAD,
    MA1, MA2, MA3, MA4, SQS, SQT, CORD, MSEG, FIN
  } state_t;

  state_t state;

  logic [3:0][31:0] ang;
  logic [3:0][63:0] vals;
  logic [1:0]  ang_idx;
  logic [3:0]  n;
  logic [63:0] x, x2, ts, tc, s, c;
  logic [1:0]  q;
  logic [63:0] t1, p, av, sv;
  logic        neg_p, neg2;
  logic [5:0]  cnt;
  logic [63:0] sq_root, sq_rem;
  logic [61:0] sq_src;
  logic [63:0] cx, cy, z;
  logic [63:0] seg;
  logic [TOTAL_WIDTH-1:0] total;

  hpo_pkg::hpo_mul_req_t mreq;
  logic        mul_done;
  logic [63:0] mul_res;

  hpo_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .done (mul_done),
    .res  (mul_res)
  );

  logic [31:0] h, r, e;
  logic [32:0] r33;
  logic [1:0]  q_nx;
  logic [63:0] sq_rem_sh, sq_trial, sq_rem_nx, sq_root_nx;
  logic        sq_ge;
  logic [63:0] dx, dy, w, cx_nx, cy_nx, z_nx, z_pos;
  logic        ypos;
  logic [63:0] sin_sel, cos_sel, a_sum, a_clamp, ext_total;
  logic [TOTAL_WIDTH-1:0] room;
  logic        out_free;

  always_comb begin
    h   = ang[ang_idx];
    r33 = {h[31], h} + (h[31] ? {1'b0, hpo_pkg::FullTurn} : 33'd0);
    r   = r33[31:0];
    if (r >= 32'(3 * 64'(hpo_pkg::QuarterTurn))) begin
      q_nx = 2'd3;
      e    = r - 32'(3 * 64'(hpo_pkg::QuarterTurn));
    end else if (r >= 32'(2 * 64'(hpo_pkg::QuarterTurn))) begin
      q_nx = 2'd2;
      e    = r - 32'(2 * 64'(hpo_pkg::QuarterTurn));
    end else if (r >= hpo_pkg::QuarterTurn) begin
      q_nx = 2'd1;
      e    = r - hpo_pkg::QuarterTurn;
    end else begin
      q_nx = 2'd0;
      e    = r;
    end

    sq_rem_sh  = {sq_rem[61:0], sq_src[61:60]};
    sq_trial   = {sq_root[61:0], 2'b01};
    sq_ge      = sq_rem_sh >= sq_trial;
    sq_rem_nx  = sq_ge ? sq_rem_sh - sq_trial : sq_rem_sh;
    sq_root_nx = {sq_root[62:0], sq_ge};

    dx    = 64'($signed(cy) >>> cnt);
    dy    = 64'($signed(cx) >>> cnt);
    ypos  = $signed(cy) > 0;
    w     = hpo_pkg::AtanTab[cnt];
    cx_nx = ypos ? cx + dx : cx - dx;
    cy_nx = ypos ? cy - dy : cy + dy;
    z_nx  = ypos ? z + w : z - w;
    z_pos = z_nx[63] ? 64'd0 : z_nx;

    unique case (q)
      2'd0: begin sin_sel = s;      cos_sel = c;      end
      2'd1: begin sin_sel = c;      cos_sel = -s;     end
      2'd2: begin sin_sel = -s;     cos_sel = -c;     end
      default: begin sin_sel = -c;  cos_sel = s;      end
    endcase

    a_sum = t1 + (neg2 ? -mul_res : mul_res);
    if (a_sum[63]) begin
      a_clamp = '0;
    end else if (a_sum > hpo_pkg::OneQ60) begin
      a_clamp = hpo_pkg::OneQ60;
    end else begin
      a_clamp = a_sum;
    end

    room      = ~total;
    ext_total = 64'(total);
    out_free  = !m_tvalid || m_tready;
    job_pop   = (state == IDLE) && job_avail;
  end

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
      total    <= '0;
      mreq     <= '0;
      cnt      <= '0;
      ang_idx  <= '0;
      n        <= '0;
    end else begin
      mreq.go <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (job_avail) begin
            ang     <= job.ang;
            ang_idx <= '0;
            if (job.first) begin
              seg   <= '0;
              state <= FIN;
            end else begin
              state <= ANG;
            end
          end
        end
        ANG: begin
          q     <= q_nx;
          mreq  <= '{go: 1'b1, rnd: 1'b1, shift: hpo_pkg::ShiftRad, a: 64'(e),
                     b: hpo_pkg::RadScale};
          state <= MX;
        end
        MX: begin
          if (mul_done) begin
            x     <= mul_res;
            mreq  <= '{go: 1'b1, rnd: 1'b1, shift: hpo_pkg::ShiftQ60, a: mul_res,
                       b: mul_res};
            state <= MX2;
          end
        end
        MX2: begin
          if (mul_done) begin
            x2    <= mul_res;
            ts    <= x;
            s     <= x;
            tc    <= hpo_pkg::OneQ60;
            c     <= hpo_pkg::OneQ60;
            n     <= 4'd1;
            mreq  <= '{go: 1'b1, rnd: 1'b1, shift: hpo_pkg::ShiftQ60, a: x, b: mul_res};
            state <= MTS;
          end
        end
        MTS: begin
          if (mul_done) begin
            mreq  <= '{go: 1'b1, rnd: 1'b0, shift: hpo_pkg::SinShift[n], a: mul_res,
                       b: hpo_pkg::SinRecip[n]};
            state <= DTS;
          end
        end
        DTS: begin
          if (mul_done) begin
            ts    <= mul_res;
            s     <= n[0] ? s - mul_res : s + mul_res;
            mreq  <= '{go: 1'b1, rnd: 1'b1, shift: hpo_pkg::ShiftQ60, a: tc, b: x2};
            state <= MTC;
          end
        end
        MTC: begin
          if (mul_done) begin
            mreq  <= '{go: 1'b1, rnd: 1'b0, shift: hpo_pkg::CosShift[n], a: mul_res,
                       b: hpo_pkg::CosRecip[n]};
            state <= DTC;
          end
        end
        DTC: begin
          if (mul_done) begin
            tc <= mul_res;
            c  <= n[0] ? c - mul_res : c + mul_res;
            if (n == 4'(hpo_pkg::TaylorTerms)) begin
              state <= QUAD;
            end else begin
              n     <= n + 4'd1;
              mreq  <= '{go: 1'b1, rnd: 1'b1, shift: hpo_pkg::ShiftQ60, a: ts, b: x2};
              state <= MTS;
            end
          end
        end
        QUAD: begin
          vals[ang_idx] <= ang_idx[1] ? cos_sel : sin_sel;
          if (ang_idx == 2'd3) begin
            mreq  <= '{go: 1'b1, rnd: 1'b1, shift: hpo_pkg::ShiftQ60, a: mag(vals[0]),
                       b: mag(vals[0])};
            state <= MA1;
          end else begin
            ang_idx <= ang_idx + 2'd1;
            state   <= ANG;
          end
        end
        MA1: begin
          if (mul_done) begin
            t1    <= mul_res;
            neg_p <= vals[2][63] ^ vals[3][63];
            mreq  <= '{go: 1'b1, rnd: 1'b1, shift: hpo_pkg::ShiftQ60, a: mag(vals[2]),
                       b: mag(vals[3])};
            state <= MA2;
          end
        end
        MA2: begin
          if (mul_done) begin
            p     <= neg_p ? -mul_res : mul_res;
            mreq  <= '{go: 1'b1, rnd: 1'b1, shift: hpo_pkg::ShiftQ60, a: mag(vals[1]),
                       b: mag(vals[1])};
            state <= MA3;
          end
        end
        MA3: begin
          if (mul_done) begin
            neg2  <= p[63];
            mreq  <= '{go: 1'b1, rnd: 1'b1, shift: hpo_pkg::ShiftQ60, a: mag(p),
                       b: mul_res};
            state <= MA4;
          end
        end
        MA4: begin
          if (mul_done) begin
            av      <= a_clamp;
            sq_src  <= a_clamp[61:0];
            sq_root <= '0;
            sq_rem  <= '0;
            cnt     <= '0;
            state   <= SQS;
          end
        end
        SQS: begin
          sq_src  <= sq_src << 2;
          sq_root <= sq_root_nx;
          sq_rem  <= sq_rem_nx;
          cnt     <= cnt + 6'd1;
          if (cnt == 6'(hpo_pkg::CordicSteps - 1)) begin
            sv      <= sq_root_nx;
            sq_src  <= 62'(hpo_pkg::OneQ60 - av);
            sq_root <= '0;
            sq_rem  <= '0;
            cnt     <= '0;
            state   <= SQT;
          end
        end
        SQT: begin
          sq_src  <= sq_src << 2;
          sq_root <= sq_root_nx;
          sq_rem  <= sq_rem_nx;
          cnt     <= cnt + 6'd1;
          if (cnt == 6'(hpo_pkg::CordicSteps - 1)) begin
            cx    <= sq_root_nx;
            cy    <= sv;
            z     <= '0;
            cnt   <= '0;
            state <= CORD;
          end
        end
        CORD: begin
          cx  <= cx_nx;
          cy  <= cy_nx;
          z   <= z_nx;
          cnt <= cnt + 6'd1;
          if (cnt == 6'(hpo_pkg::CordicSteps - 1)) begin
            mreq  <= '{go: 1'b1, rnd: 1'b1, shift: hpo_pkg::ShiftQ60, a: z_pos,
                       b: hpo_pkg::DiamScale};
            state <= MSEG;
          end
        end
        MSEG: begin
          if (mul_done) begin
            seg   <= mul_res;
            state <= FIN;
          end
        end
        FIN: begin
          if (out_free) begin
            if (65'(seg) > 65'(room)) begin
              total          <= '1;
              total_path     <= 48'(64'({TOTAL_WIDTH{1'b1}}));
            end else begin
              total          <= total + TOTAL_WIDTH'(seg);
              total_path     <= 48'(ext_total + seg);
            end
            segment_length <= seg[32:0];
            m_tvalid       <= 1'b1;
            state          <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_cord_bound: assert property (@(posedge clk) disable iff (rst)
    state == CORD |-> cnt <= 6'(hpo_pkg::CordicSteps - 1))
    else $error("CORDIC step count overran");

  a_mul_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == MX || state == MX2 || state == MTS || state == DTS ||
                  state == MTC || state == DTC ||
                  state == MA1 || state == MA2 || state == MA3 || state == MA4 ||
                  state == MSEG))
    else $error("multiplier result arrived outside a wait state");

  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    state == FIN && out_free |=> m_tvalid && state == IDLE)
    else $error("result not loaded into output register");

endmodule
`default_nettype wire

@@ src/haversine_path_odometer_core.sv @@
// Top level of the haversine path odometer: front end, job queue, back end.
// Depends on hpo_pkg, hpo_front, hpo_queue, hpo_back.
`default_nettype none
// Each accepted fix adds the great-circle distance (radius 6371000 m) from the
// previous fix to a saturating running total in 1/256 m; the first fix after
// reset adds zero. One result transaction per fix. The work for any later fix is
// set mainly by 221 products on one shared 64x64 multiplier (four 13-term
// sine/cosine series with division by reciprocal multiplication, the haversine
// term and the final scaling), plus two 61-step square roots and a 61-step
// CORDIC arctangent. Up to two fixes queue while one is in work.
module haversine_path_odometer_core #(
  parameter int TOTAL_WIDTH = 48
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // latitude[29:0], longitude[60:30], zero fill
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [87:0]      m_tdata    // total_path[47:0], segment_length[80:48], zero fill
);

  hpo_pkg::hpo_job_t front_job, queue_job;
  logic q_full, q_empty, q_pop, accept;
  logic [47:0] total_path;
  logic [32:0] segment_length;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {7'd0, segment_length, total_path};

  hpo_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .latitude  (s_tdata[29:0]),
    .longitude (s_tdata[60:30]),
    .job       (front_job)
  );

  hpo_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (queue_job),
    .empty     (q_empty)
  );

  hpo_back #(.TOTAL_WIDTH(TOTAL_WIDTH)) u_back (
    .clk            (clk),
    .rst            (rst),
    .job_avail      (!q_empty),
    .job            (queue_job),
    .job_pop        (q_pop),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .total_path     (total_path),
    .segment_length (segment_length)
  );

endmodule
`default_nettype wire

@@ bench/haversine_path_odometer_core_tb.sv @@
// Testbench for haversine_path_odometer_core: drives position fixes and checks
// path results against a bit-exact predictor built in this file.
// Depends on the haversine_path_odometer_core RTL.
module haversine_path_odometer_core_tb;

  localparam int TotalWidth = 48;
  localparam int NumItems = 1750;
  localparam longint FullTurnU = longint'(360) << 23;
  localparam longint QuarterTurnU = longint'(90) << 23;
  localparam longint OneQ = longint'(1) << 60;
  localparam longint CycleLimit = 20_000_000;
  localparam int HoldCycles = 40000;
  localparam int QuietTail = 200;

  typedef struct {
    logic [29:0] lat;
    logic [30:0] lon;
    bit pause;
  } fix_t;

  typedef struct {
    logic [47:0] total;
    logic [32:0] seg;
  } path_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [87:0] m_tdata;

  fix_t fix_q[$];
  path_t path_q[$];
  int n_errors = 0;
  int n_results = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 0;
  longint n_cycles = 0;

  // predictor state
  logic [63:0] pi_c;
  logic [63:0] rad_k;
  longint atan_w[61];
  longint prev_lat = 0, prev_lon = 0;
  bit have_prev = 0;
  logic [47:0] run_total = '0;

  haversine_path_odometer_core #(.TOTAL_WIDTH(TotalWidth)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = 128'(a) * 128'(b) + (128'd1 << (s - 1));
    return 64'(p >> s);
  endfunction

  function automatic longint qmul(longint a, longint b);
    bit neg;
    logic [63:0] m;
    neg = (a < 0) != (b < 0);
    m = mul_round(a < 0 ? -a : a, b < 0 ? -b : b, 60);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic void build_consts();
    logic [63:0] val, rem;
    longint sum, term;
    val = 3;
    rem = 64'd3141592653589793238 - 64'd3000000000000000000;
    for (int i = 0; i < 60; i++) begin
      rem = rem << 1;
      val = val << 1;
      if (rem >= 64'd1000000000000000000) begin
        rem = rem - 64'd1000000000000000000;
        val[0] = 1'b1;
      end
    end
    if (2 * rem >= 64'd1000000000000000000) val = val + 1;
    pi_c = val;
    rad_k = val / (64'd180 << 15);
    atan_w[0] = longint'((val + 2) >> 2);
    for (int i = 1; i < 61; i++) begin
      sum = 0;
      for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
        term = longint'((64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1));
        sum = (k % 2 == 1) ? sum - term : sum + term;
      end
      atan_w[i] = sum;
    end
  endfunction

  // angle in 2^-23 degree units -> Q60 sine and cosine
  function automatic void trig(longint h, output longint sn, output longint cs);
    longint r, q, e, s, c;
    logic [63:0] x, x2, ts, tc;
    r = h % FullTurnU;
    if (r < 0) r += FullTurnU;
    q = r / QuarterTurnU;
    e = r - q * QuarterTurnU;
    x = mul_round(64'(e), rad_k, 8);
    x2 = mul_round(x, x, 60);
    ts = x;
    tc = 64'(OneQ);
    s = longint'(x);
    c = OneQ;
    for (int n = 1; n <= 13; n++) begin
      ts = mul_round(ts, x2, 60) / 64'((2 * n) * (2 * n + 1));
      tc = mul_round(tc, x2, 60) / 64'((2 * n - 1) * (2 * n));
      s = (n % 2 == 1) ? s - longint'(ts) : s + longint'(ts);
      c = (n % 2 == 1) ? c - longint'(tc) : c + longint'(tc);
    end
    case (q)
      0: begin sn = s; cs = c; end
      1: begin sn = c; cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  function automatic longint root_q60(longint a);
    logic [63:0] ua, root, rem, pair, trial;
    ua = a;
    root = 0;
    rem = 0;
    for (int i = 60; i >= 0; i--) begin
      pair = (i >= 30) ? ((ua >> (2 * i - 60)) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return longint'(root);
  endfunction

  function automatic logic [63:0] great_circle(longint la1, longint lo1, longint la2,
                                               longint lo2);
    longint sla, cla, slo, clo, s1, c1, s2, c2, a, x, y, z, dx, dy;
    trig(la2 - la1, sla, cla);
    trig(lo2 - lo1, slo, clo);
    trig(2 * la1, s1, c1);
    trig(2 * la2, s2, c2);
    a = qmul(sla, sla) + qmul(qmul(c1, c2), qmul(slo, slo));
    if (a < 0) a = 0;
    if (a > OneQ) a = OneQ;
    y = root_q60(a);
    x = root_q60(OneQ - a);
    z = 0;
    for (int i = 0; i < 61; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_w[i];
      end else begin
        x -= dx; y += dy; z -= atan_w[i];
      end
    end
    if (z < 0) z = 0;
    return mul_round(64'(z), 64'd2 * 64'd6371000 * 64'd256, 60);
  endfunction

  function automatic path_t odometer_step(logic [29:0] lat_b, logic [30:0] lon_b);
    path_t p;
    longint lat, lon;
    logic [63:0] seg, tmax;
    lat = longint'($signed(lat_b));
    lon = longint'($signed(lon_b));
    tmax = (64'd1 << TotalWidth) - 1;
    seg = have_prev ? great_circle(prev_lat, prev_lon, lat, lon) : 64'd0;
    if (seg > tmax - 64'(run_total)) run_total = tmax[47:0];
    else run_total = run_total + seg[47:0];
    prev_lat = lat;
    prev_lon = lon;
    have_prev = 1;
    p.total = run_total;
    p.seg = seg[32:0];
    return p;
  endfunction

  function automatic void add_fix(longint lat, longint lon, bit pause);
    fix_t f;
    f.lat = lat[29:0];
    f.lon = lon[30:0];
    f.pause = pause;
    fix_q.push_back(f);
  endfunction

  // sender
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (!rst) begin
      if (s_tvalid && s_tready)
        path_q.push_back(odometer_step(s_tdata[29:0], s_tdata[60:30]));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 0;
        end else if (fix_q.size() > 0 &&
                     !(fix_q[0].pause && (path_q.size() > 0 || s_tvalid))) begin
          s_tvalid <= 1;
          s_tdata <= {3'b0, fix_q[0].lon, fix_q[0].lat};
          fix_q.pop_front();
          if (fix_q.size() > QuietTail && $urandom_range(0, 7) == 0)
            gap_left <= $urandom_range(1, 19);
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // long receiver hold-off once the run is under way
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
      else if (!hold_done && n_results == 40) begin
        hold_left <= HoldCycles;
        hold_done <= 1;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    path_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        n_results <= n_results + 1;
        if (path_q.size() == 0) begin
          n_errors <= n_errors + 1;
          if (n_errors < 10) $display("unexpected result transaction: %h", m_tdata);
        end else begin
          want = path_q.pop_front();
          if (m_tdata[47:0] !== want.total || m_tdata[80:48] !== want.seg) begin
            n_errors <= n_errors + 1;
            if (n_errors < 10)
              $display("result %0d: total exp %0d got %0d, segment exp %0d got %0d",
                       n_results, want.total, m_tdata[47:0], want.seg, m_tdata[80:48]);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready <= 0;
      end else if (n_results < NumItems - QuietTail && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 18);
        m_tready <= 0;
      end else begin
        m_tready <= (hold_left == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (n_cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    longint lat, lon, lat_max, lon_max;
    int pick;
    build_consts();
    lat_max = 377487360;
    lon_max = 754974720;
    // directed: first fix, same point, extremes, poles, antipodes, out-of-range
    add_fix(0, 0, 0);
    add_fix(0, 0, 0);
    add_fix(1, 1, 0);
    add_fix(lat_max, lon_max, 0);
    add_fix(-lat_max, -lon_max, 0);
    add_fix(lat_max, 0, 0);
    add_fix(-lat_max, 0, 0);
    add_fix(0, lon_max, 0);
    add_fix(0, -lon_max, 0);
    add_fix(-(longint'(1) << 29), -(longint'(1) << 30), 0);
    add_fix((longint'(1) << 29) - 1, (longint'(1) << 30) - 1, 0);
    add_fix(-(longint'(1) << 29), (longint'(1) << 30) - 1, 0);
    add_fix(123456789, -98765432, 1);
    add_fix(123456790, -98765431, 0);
    add_fix(-lat_max, lon_max, 0);
    lat = 0;
    lon = 0;
    for (int i = fix_q.size(); i < NumItems; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        lat = lat + $signed($urandom_range(0, 131072)) - 65536;
        lon = lon + $signed($urandom_range(0, 131072)) - 65536;
        if (lat > lat_max) lat = lat_max;
        if (lat < -lat_max) lat = -lat_max;
        if (lon > lon_max) lon = lon_max;
        if (lon < -lon_max) lon = -lon_max;
      end else if (pick < 85) begin
        lat = longint'($urandom_range(0, 2 * 377487360)) - lat_max;
        lon = longint'($urandom_range(0, 2 * 754974720)) - lon_max;
      end else if (pick < 95) begin
        lat = longint'($signed($urandom() & 32'h3FFF_FFFF) <<< 2) >>> 2;
        lon = longint'($signed($urandom() & 32'h7FFF_FFFF) <<< 1) >>> 1;
      end
      add_fix(lat, lon, i == 900);
    end
    repeat (10) @(posedge clk);
    rst <= 0;
    wait (fix_q.size() == 0 && !s_tvalid && path_q.size() == 0);
    repeat (200) @(posedge clk);
    if (n_errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
